[rtl/psdn_pkg.sv]
// ----------------------------------------------------------------------------
// psdn_pkg: shared types and constants for the point store
// Field widths, operation codes, controller states and the command and
// status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package psdn_pkg;

  localparam int FUNC_W     = 2;
  localparam int COORD_BITS = 24;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int SQ_W       = 2 * COORD_BITS;
  localparam int DIST_W     = SQ_W + 1;
  localparam int LAYER_W    = 8;
  localparam int IDX_W      = 10;
  localparam int EPS_W      = 23;

  localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(16);
  localparam int DEF_MAX_POINTS = 1023;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT  = 2'd0,
    FUNC_FIND    = 2'd1,
    FUNC_NEAREST = 2'd2,
    FUNC_REMOVE  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic load;    // latch the operands and restart the scan
    logic issue;   // read the next table entry
    logic commit;  // update the table and load the result register
  } ctrl_cmd_t;

  typedef struct packed {
    func_t op;
    logic  count_zero;
    logic  scan_last;
    logic  pipe_busy;
  } ctrl_status_t;

endpackage

[rtl/psdn_ram.sv]
// ----------------------------------------------------------------------------
// psdn_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module psdn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/psdn_ctrl.sv]
// ----------------------------------------------------------------------------
// psdn_ctrl: operation sequencer
// Accepts one operation, scans the table and drains the pipeline (a remove
// skips both, an empty table the scan) and commits the result to the output.
// ----------------------------------------------------------------------------
module psdn_ctrl
  import psdn_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  output ctrl_cmd_t    cmd,
  input  ctrl_status_t status
);

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (status.op == FUNC_REMOVE) begin
          state_next = ST_COMMIT;
        end else if (status.count_zero) begin
          state_next = ST_DRAIN;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.scan_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (state == ST_IDLE);
    cmd.load   = (state == ST_IDLE) && in_valid;
    cmd.issue  = (state == ST_SCAN);
    cmd.commit = (state == ST_COMMIT) && out_free;
  end

endmodule

[rtl/psdn_dpath.sv]
// ----------------------------------------------------------------------------
// psdn_dpath: point table and scan pipeline
// Holds the point memories, the fill count and the tolerance register, and
// runs a four-stage compare and distance pipeline over the stored points.
// ----------------------------------------------------------------------------
module psdn_dpath
  import psdn_pkg::*;
#(
  parameter int MAX_POINTS = DEF_MAX_POINTS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [EPS_W-1:0]             cfg_wr_data,
  input  logic [FUNC_W-1:0]            func,
  input  logic signed [COORD_BITS-1:0] x,
  input  logic signed [COORD_BITS-1:0] y,
  input  logic [LAYER_W-1:0]           layer,
  input  logic [IDX_W-1:0]             index,
  input  ctrl_cmd_t                    cmd,
  output ctrl_status_t                 status,
  output logic [IDX_W-1:0]             found_index,
  output logic                         is_new,
  output logic                         full_res,
  output logic [DIST_W-1:0]            dist_sq
);

  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int PT_W   = 2 * COORD_BITS + LAYER_W;

  // Operands of the current operation.
  logic [EPS_W-1:0]             eps;
  func_t                        op;
  logic signed [COORD_BITS-1:0] op_x;
  logic signed [COORD_BITS-1:0] op_y;
  logic [LAYER_W-1:0]           op_layer;
  logic [IDX_W-1:0]             op_index;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] scan_ctr;
  logic [CNT_W-1:0] scan_m1;

  // Memory ports.
  logic [PT_W-1:0]   pt_rdata;
  logic [0:0]        vl_rdata;
  logic              pt_we;
  logic              vl_we;
  logic [ADDR_W-1:0] vl_waddr;
  logic [CMP_W-1:0]  rm_m1;

  // Pipeline registers.
  logic                     s1_vld;
  logic [CNT_W-1:0]         s1_idx;
  logic                     s2_vld;
  logic [CNT_W-1:0]         s2_idx;
  logic signed [DIFF_W-1:0] s2_dx;
  logic signed [DIFF_W-1:0] s2_dy;
  logic                     s2_valid;
  logic                     s2_layer_ok;
  logic                     s3_vld;
  logic [CNT_W-1:0]         s3_idx;
  logic [SQ_W-1:0]          s3_sqx;
  logic [SQ_W-1:0]          s3_sqy;
  logic                     s3_valid;
  logic                     s3_match;

  // Running results of the scan.
  logic [CNT_W-1:0]  best_match;
  logic [CNT_W-1:0]  best_idx;
  logic [DIST_W-1:0] best_dist;

  // Stage logic.
  logic signed [COORD_BITS-1:0] rd_x;
  logic signed [COORD_BITS-1:0] rd_y;
  logic [LAYER_W-1:0]           rd_layer;
  logic signed [DIFF_W-1:0]     dx_c;
  logic signed [DIFF_W-1:0]     dy_c;
  logic [DIFF_W-1:0]            ax_c;
  logic [DIFF_W-1:0]            ay_c;
  logic signed [2*DIFF_W-1:0]   sqx_c;
  logic signed [2*DIFF_W-1:0]   sqy_c;
  logic [DIST_W-1:0]            sum_c;

  // Commit logic.
  logic             full;
  logic             append;
  logic             remove_ok;
  logic [CNT_W-1:0] new_idx;
  logic [CNT_W-1:0] res_found;
  logic             res_new;
  logic             res_full;
  logic [DIST_W-1:0] res_dist;
  logic [CMP_W-1:0] found_w;

  assign scan_m1 = scan_ctr - 1'b1;
  assign rm_m1   = CMP_W'(op_index) - 1'b1;

  assign full      = (count == CNT_W'(MAX_POINTS));
  assign append    = (op == FUNC_INSERT) && (best_match == '0) && !full;
  assign remove_ok = (op == FUNC_REMOVE) && (op_index != '0) &&
                     (CMP_W'(op_index) <= CMP_W'(count));
  assign new_idx   = count + 1'b1;

  assign pt_we    = cmd.commit && append;
  assign vl_we    = cmd.commit && (append || remove_ok);
  assign vl_waddr = append ? count[ADDR_W-1:0] : rm_m1[ADDR_W-1:0];

  psdn_ram #(
    .WIDTH (PT_W),
    .DEPTH (MAX_POINTS)
  ) u_point_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (count[ADDR_W-1:0]),
    .wdata ({op_x, op_y, op_layer}),
    .re    (cmd.issue),
    .raddr (scan_m1[ADDR_W-1:0]),
    .rdata (pt_rdata)
  );

  psdn_ram #(
    .WIDTH (1),
    .DEPTH (MAX_POINTS)
  ) u_valid_ram (
    .clk   (clk),
    .we    (vl_we),
    .waddr (vl_waddr),
    .wdata (append),
    .re    (cmd.issue),
    .raddr (scan_m1[ADDR_W-1:0]),
    .rdata (vl_rdata)
  );

  assign rd_x     = signed'(pt_rdata[PT_W-1 -: COORD_BITS]);
  assign rd_y     = signed'(pt_rdata[LAYER_W +: COORD_BITS]);
  assign rd_layer = pt_rdata[LAYER_W-1:0];

  assign dx_c = signed'({op_x[COORD_BITS-1], op_x}) - signed'({rd_x[COORD_BITS-1], rd_x});
  assign dy_c = signed'({op_y[COORD_BITS-1], op_y}) - signed'({rd_y[COORD_BITS-1], rd_y});

  assign ax_c  = s2_dx[DIFF_W-1] ? unsigned'(-s2_dx) : unsigned'(s2_dx);
  assign ay_c  = s2_dy[DIFF_W-1] ? unsigned'(-s2_dy) : unsigned'(s2_dy);
  assign sqx_c = s2_dx * s2_dx;
  assign sqy_c = s2_dy * s2_dy;

  assign sum_c = DIST_W'(s3_sqx) + DIST_W'(s3_sqy);

  assign status.op         = op;
  assign status.count_zero = (count == '0);
  assign status.scan_last  = (scan_ctr == count);
  assign status.pipe_busy  = s1_vld || s2_vld || s3_vld;

  always_comb begin
    res_found = '0;
    res_new   = 1'b0;
    res_full  = 1'b0;
    res_dist  = '0;
    case (op)
      FUNC_INSERT: begin
        if (best_match != '0) begin
          res_found = best_match;
        end else if (!full) begin
          res_found = new_idx;
          res_new   = 1'b1;
        end else begin
          res_full = 1'b1;
        end
      end
      FUNC_FIND: begin
        res_found = best_match;
      end
      FUNC_NEAREST: begin
        res_found = best_idx;
        res_dist  = best_dist;
      end
      default: begin
        res_found = '0;
      end
    endcase
  end

  assign found_w = CMP_W'(res_found);

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      eps    <= EPS_RESET;
      count  <= '0;
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        eps <= cfg_wr_data;
      end
      if (cmd.commit && append) begin
        count <= new_idx;
      end
      s1_vld <= cmd.issue;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
    end
  end

  // Operands, scan counter, pipeline payload and results.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op         <= func_t'(func);
      op_x       <= x;
      op_y       <= y;
      op_layer   <= layer;
      op_index   <= index;
      scan_ctr   <= CNT_W'(1);
      best_match <= '0;
      best_idx   <= '0;
      best_dist  <= '0;
    end else begin
      if (cmd.issue) begin
        scan_ctr <= scan_ctr + 1'b1;
      end
      if (s3_vld && s3_valid) begin
        if (s3_match && (best_match == '0)) begin
          best_match <= s3_idx;
        end
        if ((best_idx == '0) || (sum_c < best_dist)) begin
          best_idx  <= s3_idx;
          best_dist <= sum_c;
        end
      end
    end

    s1_idx      <= scan_ctr;
    s2_idx      <= s1_idx;
    s2_dx       <= dx_c;
    s2_dy       <= dy_c;
    s2_valid    <= vl_rdata[0];
    s2_layer_ok <= (op_layer == '0) || (op_layer == rd_layer);
    s3_idx      <= s2_idx;
    s3_sqx      <= sqx_c[SQ_W-1:0];
    s3_sqy      <= sqy_c[SQ_W-1:0];
    s3_valid    <= s2_valid;
    s3_match    <= s2_layer_ok && (ax_c <= DIFF_W'(eps)) && (ay_c <= DIFF_W'(eps));

    if (cmd.commit) begin
      found_index <= found_w[IDX_W-1:0];
      is_new      <= res_new;
      full_res    <= res_full;
      dist_sq     <= res_dist;
    end
  end

endmodule

[rtl/point_store_dedup_nearest_core.sv]
// ----------------------------------------------------------------------------
// point_store_dedup_nearest_core: 2-D point table with match and nearest search
// Stores points with Q12.12 coordinates and a layer tag. Supports insert
// with duplicate detection, find, nearest-point search and remove.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Payload
//   in        input      in_valid / in_ready    func, x, y, layer, index
//   out       output     out_valid / out_ready  found_index, is_new,
//                                               full_res, dist_sq
//   cfg       input      cfg_wr_en              cfg_wr_data (match epsilon)
//
// Insert, find and nearest read every entry up to the fill count through
// one memory read port, one entry per cycle.
// Reset (rst, synchronous) empties the table by zeroing the fill count and
// sets the tolerance to 16; no clearing pass is needed.
// A result waiting in the output register does not block the next transfer
// in; only the commit of the following result waits for it to be taken.
//
// Operation flow: the controller latches an operation, then streams the
// table addresses into a pipeline of memory read, coordinate difference,
// squaring and accumulate. The accumulate stage keeps the lowest-index
// match within tolerance and the lowest-index point at minimum squared
// distance. When the pipeline has drained, the commit cycle appends a new
// point (insert with no match and room left), clears a valid bit (remove
// within range) and loads the result register.
//
// Entries beyond the fill count are never read, and every entry at or
// below it was written at append, so the valid store needs no reset.
// ----------------------------------------------------------------------------
module point_store_dedup_nearest_core
  import psdn_pkg::*;
#(
  parameter int MAX_POINTS = DEF_MAX_POINTS
) (
  input  logic                         clk,
  input  logic                         rst,

  input  logic                         cfg_wr_en,
  input  logic [EPS_W-1:0]             cfg_wr_data,

  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [FUNC_W-1:0]            func,
  input  logic signed [COORD_BITS-1:0] x,
  input  logic signed [COORD_BITS-1:0] y,
  input  logic [LAYER_W-1:0]           layer,
  input  logic [IDX_W-1:0]             index,

  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [IDX_W-1:0]             found_index,
  output logic                         is_new,
  output logic                         full_res,
  output logic [DIST_W-1:0]            dist_sq
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  // The controller owns the handshakes and the sequencing; all storage
  // and arithmetic live in the datapath.
  psdn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  psdn_dpath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .func        (func),
    .x           (x),
    .y           (y),
    .layer       (layer),
    .index       (index),
    .cmd         (cmd),
    .status      (status),
    .found_index (found_index),
    .is_new      (is_new),
    .full_res    (full_res),
    .dist_sq     (dist_sq)
  );

endmodule
